// ----- rtl/pee_pkg.sv -----
// Shared constants, codes and command/status structs of the postfix expression evaluator.
package pee_pkg;

    localparam int STACK_DEPTH = 128;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int PTR_W       = $clog2(STACK_DEPTH);
    localparam int DATA_W      = 32;
    localparam int STEP_W      = 5;
    localparam int DEPTH_OUT_W = 8;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_UNDER = 3'd1,
        ST_OVER  = 3'd2,
        ST_DIVZ  = 3'd3,
        ST_BADCH = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        CLS_SKIP,
        CLS_DIGIT,
        CLS_OPER,
        CLS_BAD
    } t_cls;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_POW
    } t_op;

    typedef struct packed {
        logic    load;
        logic    push;
        logic    set_err;
        t_status err_code;
        logic    rd;
        logic    alu_wr;
        logic    start;
        logic    step;
        logic    wb;
        logic    emit;
    } t_cmd;

    typedef struct packed {
        t_cls cls;
        t_op  op;
        logic err_any;
        logic full;
        logic few;
        logic b_zero;
        logic b_neg;
        logic a_zero;
        logic step_last;
    } t_sts;

endpackage

// ----- rtl/postfix_expression_evaluator_core.sv -----
// Top level of the postfix expression evaluator: controller plus datapath.
//
// Channel | Direction | Handshake                 | Payload
// input   | in        | i_in_valid / o_in_stall   | i_char_code, i_end_of_expr
// output  | out       | o_out_valid / i_out_stall | o_status, o_top_value,
//         |           |                           | o_stack_depth, o_final_valid
//
// Whitespace, digits, stack and character faults and any beat after a fault go from load
// through execute to emit; + and -, a zero divisor and a negative exponent also read the
// operands; *, ^ and / then iterate and write back, ^ in the 31-step square-and-multiply
// loop and / in the 32-step restoring divider. One beat is in progress at a time.
// Synchronous reset clears the stack count and error status; the stack memory is not cleared.
// A finished result waits in the output register while the next beat is worked on.
module postfix_expression_evaluator_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [7:0]                          i_char_code,
    input  logic                                i_end_of_expr,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [2:0]                          o_status,
    output logic signed [pee_pkg::DATA_W-1:0]   o_top_value,
    output logic [pee_pkg::DEPTH_OUT_W-1:0]     o_stack_depth,
    output logic                                o_final_valid
);

    pee_pkg::t_cmd w_cmd;
    pee_pkg::t_sts w_sts;

    pee_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    pee_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_char_code   (i_char_code),
        .i_end_of_expr (i_end_of_expr),
        .o_sts         (w_sts),
        .o_status      (o_status),
        .o_top_value   (o_top_value),
        .o_stack_depth (o_stack_depth),
        .o_final_valid (o_final_valid)
    );

endmodule

// ----- rtl/pee_ctrl.sv -----
// Sequencing state machine of the postfix expression evaluator.
module pee_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_out_stall,
    input  pee_pkg::t_sts i_sts,
    output pee_pkg::t_cmd o_cmd,
    output logic          o_in_stall,
    output logic          o_out_valid
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_OPND,
        S_ITER,
        S_WB,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd    = '0;
        o_cmd.err_code = pee_pkg::ST_OK;
        n_state  = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_EMIT;
                if (!i_sts.err_any) begin
                    unique case (i_sts.cls)
                        pee_pkg::CLS_SKIP: ;
                        pee_pkg::CLS_DIGIT: begin
                            if (i_sts.full) begin
                                o_cmd.set_err  = 1'b1;
                                o_cmd.err_code = pee_pkg::ST_OVER;
                            end else begin
                                o_cmd.push = 1'b1;
                            end
                        end
                        pee_pkg::CLS_OPER: begin
                            if (i_sts.few) begin
                                o_cmd.set_err  = 1'b1;
                                o_cmd.err_code = pee_pkg::ST_UNDER;
                            end else begin
                                o_cmd.rd = 1'b1;
                                n_state  = S_OPND;
                            end
                        end
                        default: begin
                            o_cmd.set_err  = 1'b1;
                            o_cmd.err_code = pee_pkg::ST_BADCH;
                        end
                    endcase
                end
            end
            S_OPND: begin
                n_state = S_EMIT;
                unique case (i_sts.op)
                    pee_pkg::OP_ADD, pee_pkg::OP_SUB: begin
                        o_cmd.alu_wr = 1'b1;
                    end
                    pee_pkg::OP_MUL: begin
                        o_cmd.start = 1'b1;
                        n_state     = S_ITER;
                    end
                    pee_pkg::OP_DIV: begin
                        if (i_sts.b_zero) begin
                            o_cmd.set_err  = 1'b1;
                            o_cmd.err_code = pee_pkg::ST_DIVZ;
                        end else begin
                            o_cmd.start = 1'b1;
                            n_state     = S_ITER;
                        end
                    end
                    pee_pkg::OP_POW: begin
                        if (!i_sts.b_neg) begin
                            o_cmd.start = 1'b1;
                            n_state     = S_ITER;
                        end else if (i_sts.a_zero) begin
                            o_cmd.set_err  = 1'b1;
                            o_cmd.err_code = pee_pkg::ST_DIVZ;
                        end else begin
                            o_cmd.alu_wr = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            S_ITER: begin
                o_cmd.step = 1'b1;
                if (i_sts.step_last) begin
                    n_state = S_WB;
                end
            end
            S_WB: begin
                o_cmd.wb = 1'b1;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ----- rtl/pee_dpath.sv -----
// Stack, arithmetic units and result register of the postfix expression evaluator.
module pee_dpath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pee_pkg::t_cmd                       i_cmd,
    input  logic [7:0]                          i_char_code,
    input  logic                                i_end_of_expr,
    output pee_pkg::t_sts                       o_sts,
    output logic [2:0]                          o_status,
    output logic signed [pee_pkg::DATA_W-1:0]   o_top_value,
    output logic [pee_pkg::DEPTH_OUT_W-1:0]     o_stack_depth,
    output logic                                o_final_valid
);

    localparam int DW = pee_pkg::DATA_W;

    function automatic logic [DW-1:0] mag(input logic [DW-1:0] v);
        return v[DW-1] ? ({DW{1'b0}} - v) : v;
    endfunction

    logic [DW-1:0]             r_mem [pee_pkg::STACK_DEPTH];
    logic [7:0]                r_ch;
    logic                      r_last;
    logic [pee_pkg::CNT_W-1:0] r_cnt;
    pee_pkg::t_status          r_err;
    logic [DW-1:0]             r_tos;
    logic [DW-1:0]             r_rd;
    logic [DW-1:0]             r_rem;
    logic [DW-1:0]             r_quo;
    logic [DW-1:0]             r_dvs;
    logic                      r_neg;
    logic [DW-1:0]             r_acc;
    logic [DW-1:0]             r_sq;
    logic [DW-1:0]             r_ex;
    logic [pee_pkg::STEP_W-1:0] r_step;
    logic [2:0]                r_o_status;
    logic [DW-1:0]             r_o_top;
    logic [pee_pkg::DEPTH_OUT_W-1:0] r_o_depth;
    logic                      r_o_final;

    pee_pkg::t_cls             w_cls;
    pee_pkg::t_op              w_op;
    logic [pee_pkg::CNT_W-1:0] w_cnt_m1;
    logic [pee_pkg::CNT_W-1:0] w_cnt_m2;
    logic [7:0]                w_dig;
    logic [DW-1:0]             w_alu;
    logic [DW:0]               w_trial;
    logic [DW:0]               w_diff;
    logic [DW-1:0]             w_mul_acc;
    logic [DW-1:0]             w_mul_sq;
    logic [DW-1:0]             w_div_res;
    logic [pee_pkg::CNT_W+pee_pkg::DEPTH_OUT_W-1:0] w_cnt_ext;
    logic                      w_fin_ok;

    always_comb begin
        case (r_ch) inside
            pee_pkg::CH_SPACE, pee_pkg::CH_CR, pee_pkg::CH_LF: w_cls = pee_pkg::CLS_SKIP;
            [pee_pkg::CH_ZERO:pee_pkg::CH_NINE]:               w_cls = pee_pkg::CLS_DIGIT;
            pee_pkg::CH_PLUS, pee_pkg::CH_MINUS, pee_pkg::CH_STAR,
            pee_pkg::CH_SLASH, pee_pkg::CH_CARET:               w_cls = pee_pkg::CLS_OPER;
            default:                                            w_cls = pee_pkg::CLS_BAD;
        endcase
    end

    always_comb begin
        unique case (r_ch)
            pee_pkg::CH_PLUS:  w_op = pee_pkg::OP_ADD;
            pee_pkg::CH_MINUS: w_op = pee_pkg::OP_SUB;
            pee_pkg::CH_STAR:  w_op = pee_pkg::OP_MUL;
            pee_pkg::CH_SLASH: w_op = pee_pkg::OP_DIV;
            default:           w_op = pee_pkg::OP_POW;
        endcase
    end

    assign w_cnt_m1 = r_cnt - 1'b1;
    assign w_cnt_m2 = r_cnt - 2'd2;
    assign w_dig    = r_ch - pee_pkg::CH_ZERO;

    // A negative exponent only leaves a nonzero result for a base of one or minus one.
    always_comb begin
        case (w_op)
            pee_pkg::OP_ADD: w_alu = r_rd + r_tos;
            pee_pkg::OP_SUB: w_alu = r_rd - r_tos;
            default: begin
                if (r_rd == DW'(1)) begin
                    w_alu = DW'(1);
                end else if (r_rd == {DW{1'b1}}) begin
                    w_alu = r_tos[0] ? {DW{1'b1}} : DW'(1);
                end else begin
                    w_alu = '0;
                end
            end
        endcase
    end

    assign w_trial   = {r_rem, r_quo[DW-1]};
    assign w_diff    = w_trial - {1'b0, r_dvs};
    assign w_mul_acc = r_acc * r_sq;
    assign w_mul_sq  = r_sq * r_sq;
    assign w_div_res = r_neg ? ({DW{1'b0}} - r_quo) : r_quo;
    assign w_cnt_ext = {{pee_pkg::DEPTH_OUT_W{1'b0}}, r_cnt};
    assign w_fin_ok  = (r_err == pee_pkg::ST_OK) && (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.push && (r_cnt != '0)) begin
            r_mem[w_cnt_m1[pee_pkg::PTR_W-1:0]] <= r_tos;
        end
        if (i_cmd.rd) begin
            r_rd <= r_mem[w_cnt_m2[pee_pkg::PTR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_err <= pee_pkg::ST_OK;
        end else begin
            if (i_cmd.push) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.alu_wr || i_cmd.wb) begin
                r_cnt <= w_cnt_m1;
            end
            if (i_cmd.set_err) begin
                r_err <= i_cmd.err_code;
            end
            if (i_cmd.emit && r_last) begin
                r_cnt <= '0;
                r_err <= pee_pkg::ST_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ch   <= i_char_code;
            r_last <= i_end_of_expr;
        end
        if (i_cmd.push) begin
            r_tos <= {{(DW-8){1'b0}}, w_dig};
        end else if (i_cmd.alu_wr) begin
            r_tos <= w_alu;
        end else if (i_cmd.wb) begin
            r_tos <= (w_op == pee_pkg::OP_DIV) ? w_div_res : r_acc;
        end
        if (i_cmd.start) begin
            unique case (w_op)
                pee_pkg::OP_DIV: begin
                    r_rem  <= '0;
                    r_quo  <= mag(r_rd);
                    r_dvs  <= mag(r_tos);
                    r_neg  <= r_rd[DW-1] ^ r_tos[DW-1];
                    r_step <= pee_pkg::STEP_W'(DW - 1);
                end
                pee_pkg::OP_MUL: begin
                    r_acc  <= r_rd;
                    r_sq   <= r_tos;
                    r_ex   <= DW'(1);
                    r_step <= '0;
                end
                default: begin
                    r_acc  <= DW'(1);
                    r_sq   <= r_rd;
                    r_ex   <= r_tos;
                    r_step <= pee_pkg::STEP_W'(DW - 2);
                end
            endcase
        end else if (i_cmd.step) begin
            r_step <= r_step - 1'b1;
            if (w_op == pee_pkg::OP_DIV) begin
                r_quo <= {r_quo[DW-2:0], !w_diff[DW]};
                r_rem <= w_diff[DW] ? w_trial[DW-1:0] : w_diff[DW-1:0];
            end else begin
                if (r_ex[0]) begin
                    r_acc <= w_mul_acc;
                end
                r_sq <= w_mul_sq;
                r_ex <= {1'b0, r_ex[DW-1:1]};
            end
        end
        if (i_cmd.emit) begin
            if (r_last) begin
                r_o_status <= (r_err == pee_pkg::ST_OK && r_cnt == '0) ?
                              pee_pkg::ST_UNDER : r_err;
                r_o_top    <= w_fin_ok ? r_tos : '0;
                r_o_depth  <= '0;
                r_o_final  <= w_fin_ok;
            end else begin
                r_o_status <= r_err;
                r_o_top    <= (r_cnt != '0) ? r_tos : '0;
                r_o_depth  <= w_cnt_ext[pee_pkg::DEPTH_OUT_W-1:0];
                r_o_final  <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts           = '0;
        o_sts.cls       = w_cls;
        o_sts.op        = w_op;
        o_sts.err_any   = (r_err != pee_pkg::ST_OK);
        o_sts.full      = (r_cnt == pee_pkg::CNT_W'(pee_pkg::STACK_DEPTH));
        o_sts.few       = (r_cnt < pee_pkg::CNT_W'(2));
        o_sts.b_zero    = (r_tos == '0);
        o_sts.b_neg     = r_tos[DW-1];
        o_sts.a_zero    = (r_rd == '0);
        o_sts.step_last = (r_step == '0);
    end

    assign o_status      = r_o_status;
    assign o_top_value   = $signed(r_o_top);
    assign o_stack_depth = r_o_depth;
    assign o_final_valid = r_o_final;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= pee_pkg::CNT_W'(pee_pkg::STACK_DEPTH))
        else $error("stack count beyond stack depth");

    a_push_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("push did not raise the stack count");

    a_last_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && r_last) |=> (r_cnt == '0 && r_err == pee_pkg::ST_OK))
        else $error("last beat did not clear the stack");

    a_final_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && !r_last) |=> (!r_o_final))
        else $error("final value flagged on a beat that is not last");

endmodule

// ----- sim/postfix_result_checker.sv -----
// Checker that predicts every postfix evaluator result beat and compares it with the DUT output.
module postfix_result_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  logic [7:0]                          i_char_code,
    input  logic                                i_end_of_expr,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic [2:0]                          i_status,
    input  logic signed [pee_pkg::DATA_W-1:0]   i_top_value,
    input  logic [pee_pkg::DEPTH_OUT_W-1:0]     i_stack_depth,
    input  logic                                i_final_valid,
    output int                                  o_fail_count,
    output int                                  o_pending
);

    typedef struct packed {
        logic [2:0]                      status;
        logic [pee_pkg::DATA_W-1:0]      top_value;
        logic [pee_pkg::DEPTH_OUT_W-1:0] stack_depth;
        logic                            final_valid;
    } t_result;

    logic [pee_pkg::DATA_W-1:0] eval_stack [pee_pkg::STACK_DEPTH];
    int unsigned                eval_count = 0;
    pee_pkg::t_status           eval_err   = pee_pkg::ST_OK;
    t_result                    predicted_results [$];
    int                         fail_total = 0;

    function automatic logic [pee_pkg::DATA_W-1:0] magnitude(
        input logic [pee_pkg::DATA_W-1:0] v);
        return v[pee_pkg::DATA_W-1] ? (32'd0 - v) : v;
    endfunction

    function automatic logic [pee_pkg::DATA_W-1:0] trunc_quotient(
        input logic [pee_pkg::DATA_W-1:0] a,
        input logic [pee_pkg::DATA_W-1:0] b);
        logic [pee_pkg::DATA_W-1:0] q;
        q = magnitude(a) / magnitude(b);
        return (a[pee_pkg::DATA_W-1] ^ b[pee_pkg::DATA_W-1]) ? (32'd0 - q) : q;
    endfunction

    function automatic logic [pee_pkg::DATA_W-1:0] power_wrap(
        input logic [pee_pkg::DATA_W-1:0] base,
        input logic [pee_pkg::DATA_W-1:0] ex);
        logic [pee_pkg::DATA_W-1:0] acc;
        logic [pee_pkg::DATA_W-1:0] sq;
        int                         i;
        acc = 32'd1;
        sq  = base;
        for (i = 0; i < 31; i++) begin
            if (ex[i]) begin
                acc = acc * sq;
            end
            sq = sq * sq;
        end
        return acc;
    endfunction

    task automatic apply_char(input logic [7:0] ch);
        logic [pee_pkg::DATA_W-1:0] lhs;
        logic [pee_pkg::DATA_W-1:0] rhs;
        logic [pee_pkg::DATA_W-1:0] res;
        logic                       fault;
        fault = 1'b0;
        res   = '0;
        if (ch == pee_pkg::CH_SPACE || ch == pee_pkg::CH_CR || ch == pee_pkg::CH_LF) begin
        end else if (ch >= pee_pkg::CH_ZERO && ch <= pee_pkg::CH_NINE) begin
            if (eval_count >= pee_pkg::STACK_DEPTH) begin
                eval_err = pee_pkg::ST_OVER;
            end else begin
                eval_stack[eval_count] = {{(pee_pkg::DATA_W-8){1'b0}}, ch - pee_pkg::CH_ZERO};
                eval_count++;
            end
        end else if (ch == pee_pkg::CH_PLUS || ch == pee_pkg::CH_MINUS ||
                     ch == pee_pkg::CH_STAR || ch == pee_pkg::CH_SLASH ||
                     ch == pee_pkg::CH_CARET) begin
            if (eval_count < 2) begin
                eval_err = pee_pkg::ST_UNDER;
            end else begin
                rhs = eval_stack[eval_count-1];
                lhs = eval_stack[eval_count-2];
                case (ch)
                    pee_pkg::CH_PLUS:  res = lhs + rhs;
                    pee_pkg::CH_MINUS: res = lhs - rhs;
                    pee_pkg::CH_STAR:  res = lhs * rhs;
                    pee_pkg::CH_SLASH: begin
                        if (rhs == '0) fault = 1'b1;
                        else res = trunc_quotient(lhs, rhs);
                    end
                    default: begin
                        if (rhs[pee_pkg::DATA_W-1]) begin
                            if (lhs == '0) fault = 1'b1;
                            else if (lhs == 32'd1) res = 32'd1;
                            else if (&lhs) res = rhs[0] ? 32'hFFFF_FFFF : 32'd1;
                            else res = '0;
                        end else begin
                            res = power_wrap(lhs, rhs);
                        end
                    end
                endcase
                if (fault) begin
                    eval_err = pee_pkg::ST_DIVZ;
                end else begin
                    eval_count--;
                    eval_stack[eval_count-1] = res;
                end
            end
        end else begin
            eval_err = pee_pkg::ST_BADCH;
        end
    endtask

    task automatic predict_beat(input logic [7:0] ch, input logic last);
        t_result r;
        r.top_value   = '0;
        r.final_valid = 1'b0;
        if (eval_err == pee_pkg::ST_OK) apply_char(ch);
        if (last) begin
            if (eval_err == pee_pkg::ST_OK) begin
                if (eval_count == 0) begin
                    eval_err = pee_pkg::ST_UNDER;
                end else begin
                    r.top_value   = eval_stack[eval_count-1];
                    r.final_valid = 1'b1;
                end
            end
            r.status      = eval_err;
            r.stack_depth = '0;
            eval_count    = 0;
            eval_err      = pee_pkg::ST_OK;
        end else begin
            if (eval_count > 0) r.top_value = eval_stack[eval_count-1];
            r.status      = eval_err;
            r.stack_depth = eval_count[pee_pkg::DEPTH_OUT_W-1:0];
        end
        predicted_results.push_back(r);
    endtask

    task automatic check_result();
        t_result want;
        if (predicted_results.size() == 0) begin
            $error("result beat arrived with no prediction waiting");
            fail_total++;
        end else begin
            want = predicted_results.pop_front();
            if (i_status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, i_status);
                fail_total++;
            end
            if (i_top_value !== want.top_value) begin
                $error("top_value: expected %0d, got %0d",
                       $signed(want.top_value), i_top_value);
                fail_total++;
            end
            if (i_stack_depth !== want.stack_depth) begin
                $error("stack_depth: expected %0d, got %0d", want.stack_depth, i_stack_depth);
                fail_total++;
            end
            if (i_final_valid !== want.final_valid) begin
                $error("final_valid: expected %0d, got %0d", want.final_valid, i_final_valid);
                fail_total++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            eval_count = 0;
            eval_err   = pee_pkg::ST_OK;
            predicted_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) check_result();
            if (i_in_valid && !i_in_stall) predict_beat(i_char_code, i_end_of_expr);
        end
        o_fail_count <= fail_total;
        o_pending    <= predicted_results.size();
    end

endmodule

// ----- sim/postfix_expression_evaluator_core_tb.sv -----
// Testbench top that drives character beats into the postfix evaluator and reports the verdict.
module postfix_expression_evaluator_core_tb;

    logic                                i_clk;
    logic                                i_rst_n       = 1'b0;
    logic                                i_in_valid    = 1'b0;
    logic [7:0]                          i_char_code   = 8'h00;
    logic                                i_end_of_expr = 1'b0;
    logic                                i_out_stall   = 1'b0;
    logic                                o_in_stall;
    logic                                o_out_valid;
    logic [2:0]                          o_status;
    logic signed [pee_pkg::DATA_W-1:0]   o_top_value;
    logic [pee_pkg::DEPTH_OUT_W-1:0]     o_stack_depth;
    logic                                o_final_valid;

    int fail_count;
    int pending_beats;
    int items_sent  = 0;
    int stall_run   = 0;
    int stall_pick;
    bit steady      = 1'b0;

    postfix_expression_evaluator_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_char_code   (i_char_code),
        .i_end_of_expr (i_end_of_expr),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_top_value   (o_top_value),
        .o_stack_depth (o_stack_depth),
        .o_final_valid (o_final_valid)
    );

    postfix_result_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_char_code   (i_char_code),
        .i_end_of_expr (i_end_of_expr),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_status      (o_status),
        .i_top_value   (o_top_value),
        .i_stack_depth (o_stack_depth),
        .i_final_valid (o_final_valid),
        .o_fail_count  (fail_count),
        .o_pending     (pending_beats)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("[postfix_expression_evaluator_core] ERROR");
        $finish;
    end

    always @(posedge i_clk) begin
        if (stall_run == 0) begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 50) begin
                i_out_stall <= 1'b0;
                stall_run = $urandom_range(1, 6);
            end else if (stall_pick < 80) begin
                i_out_stall <= 1'b1;
                stall_run = $urandom_range(1, 3);
            end else if (stall_pick < 92) begin
                i_out_stall <= 1'b0;
                stall_run = $urandom_range(20, 100);
            end else if (stall_pick < 97) begin
                i_out_stall <= 1'b1;
                stall_run = $urandom_range(4, 12);
            end else begin
                i_out_stall <= 1'b1;
                stall_run = $urandom_range(20, 60);
            end
        end else begin
            stall_run--;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] random_digit();
        return pee_pkg::CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] random_op();
        case ($urandom_range(0, 4))
            0:       return pee_pkg::CH_PLUS;
            1:       return pee_pkg::CH_MINUS;
            2:       return pee_pkg::CH_STAR;
            3:       return pee_pkg::CH_SLASH;
            default: return pee_pkg::CH_CARET;
        endcase
    endfunction

    function automatic logic [7:0] random_space();
        case ($urandom_range(0, 2))
            0:       return pee_pkg::CH_SPACE;
            1:       return pee_pkg::CH_CR;
            default: return pee_pkg::CH_LF;
        endcase
    endfunction

    function automatic logic [7:0] random_symbol();
        case ($urandom_range(0, 2))
            0:       return random_digit();
            1:       return random_op();
            default: return random_space();
        endcase
    endfunction

    task automatic send_beat(input logic [7:0] ch, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_char_code   <= ch;
        i_end_of_expr <= last;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) begin
            send_beat(s[i], i == s.len() - 1);
        end
    endtask

    task automatic send_wellformed_expr();
        int         digits_left;
        int         depth;
        bit         trailing;
        logic [7:0] ch;
        digits_left = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 24)
                                                  : $urandom_range(1, 6);
        depth       = 0;
        trailing    = ($urandom_range(0, 9) == 0);
        while (digits_left > 0 || depth > 1) begin
            if ($urandom_range(0, 5) == 0) send_beat(random_space(), 1'b0);
            if (depth < 2 || (digits_left > 0 && $urandom_range(0, 1) == 1)) begin
                ch = random_digit();
                digits_left--;
                depth++;
            end else begin
                ch = random_op();
                depth--;
            end
            send_beat(ch, !trailing && digits_left == 0 && depth == 1);
        end
        if (trailing) send_beat(random_space(), 1'b1);
    endtask

    task automatic send_noise();
        int         len;
        int         i;
        logic [7:0] ch;
        len = $urandom_range(1, 10);
        for (i = 0; i < len; i++) begin
            ch = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 255)) : random_symbol();
            send_beat(ch, i == len - 1 || $urandom_range(0, 15) == 0);
        end
    endtask

    task automatic send_deep_stack();
        int n;
        int k;
        int i;
        n = $urandom_range(pee_pkg::STACK_DEPTH - 4, pee_pkg::STACK_DEPTH + 6);
        k = $urandom_range(0, 5);
        for (i = 0; i < n; i++) send_beat(random_digit(), 1'b0);
        for (i = 0; i < k; i++) send_beat(random_op(), 1'b0);
        send_beat(($urandom_range(0, 1) == 1) ? pee_pkg::CH_PLUS : pee_pkg::CH_SPACE, 1'b1);
    endtask

    initial begin
        int pick;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The first expression builds two to the 31st and divides it by minus one.
        send_text("256*1+^01-/");
        send_text("01-\r\n01-^");
        send_text("001-^9");
        send_text("1201-^+");
        send_text("7+");
        send_beat(8'h09, 1'b1);
        send_beat(pee_pkg::CH_SPACE, 1'b1);

        items_sent = 0;
        send_deep_stack();
        while (items_sent < 1250) begin
            steady = ($urandom_range(0, 4) == 0);
            pick   = $urandom_range(0, 99);
            if (pick < 75) send_wellformed_expr();
            else if (pick < 99) send_noise();
            else send_deep_stack();
        end
        i_in_valid <= 1'b0;

        do @(posedge i_clk); while (pending_beats != 0);
        repeat (64) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[postfix_expression_evaluator_core] OK");
        end else begin
            $display("[postfix_expression_evaluator_core] ERROR");
        end
        $finish;
    end

endmodule
